FILE: src/vcrc_pkg.sv
// ============================================================================
// vcrc_pkg
// Shared types and constants of the vehicle candidate rule classifier.
// ============================================================================
`default_nettype none

package vcrc_pkg;

  typedef enum logic [2:0] {
    CLS_NONE       = 3'd0,
    CLS_DAY        = 3'd1,
    CLS_NIGHT_LAMP = 3'd2,
    CLS_NIGHT_EDGE = 3'd3,
    CLS_BIG_BLACK  = 3'd4,
    CLS_CORNER     = 3'd5
  } vcrc_class_t;

  typedef logic [15:0] vcrc_score_t;

  // Classified group as it travels from the front to the back.
  // meas_a is the ranking measure for the class; meas_b is the horizontal
  // edge magnitude used by the second night-edge tracker. ov is zero when
  // the overlap does not count.
  typedef struct packed {
    vcrc_class_t cls;
    vcrc_score_t meas_a;
    vcrc_score_t meas_b;
    vcrc_score_t ov;
    logic        last;
  } vcrc_meas_t;

  localparam int NUM_TRACKERS   = 6;
  localparam int MEAS_B_TRACKER = 3;

  localparam vcrc_class_t TRK_CLASS [NUM_TRACKERS] = '{
    CLS_DAY, CLS_NIGHT_LAMP, CLS_NIGHT_EDGE, CLS_NIGHT_EDGE, CLS_BIG_BLACK, CLS_CORNER
  };

  localparam logic signed [15:0] VE_HI_MIN    = 16'sd15;
  localparam logic signed [15:0] SD_HI_MIN    = 16'sd85;
  localparam logic signed [15:0] BB_HI_MIN    = 16'sd60;
  localparam logic signed [15:0] HE_LV2_MIN   = 16'sd40;
  localparam logic signed [15:0] HE_LV1_MIN   = 16'sd20;
  localparam logic signed [15:0] OV_MIN       = 16'sd90;
  localparam logic signed [15:0] DS_LV2_ABOVE = 16'sd4000;
  localparam logic signed [15:0] DS_LV1_ABOVE = 16'sd3000;
  localparam logic signed [15:0] BSD_HI_ABOVE = 16'sd70;
  localparam logic signed [15:0] LAMP_LV2_MIN = 16'sd3;
  localparam logic signed [15:0] LAMP_LV1_MIN = 16'sd2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = 1;
  localparam int QCNT_BITS   = 2;

endpackage

`default_nettype wire

FILE: src/vcrc_if.sv
// ============================================================================
// vcrc_if
// Valid/ready channels of the classifier: pair groups in, row results out.
// ============================================================================
`default_nettype none

interface vcrc_in_if #(parameter int COLUMN_BITS = 10) ();
  logic                   valid;
  logic                   ready;
  logic signed [15:0]     distance;
  logic signed [15:0]     bridge_shadow;
  logic                   corner_flag;
  logic signed [15:0]     ve_density;
  logic signed [15:0]     lamp_count;
  logic signed [15:0]     shadow_spread;
  logic signed [15:0]     block_shadow;
  logic signed [15:0]     horiz_edge;
  logic signed [15:0]     overlap;
  logic [COLUMN_BITS-1:0] left_col;
  logic [COLUMN_BITS-1:0] right_col;
  logic                   last;

  modport source (
    output valid, distance, bridge_shadow, corner_flag, ve_density, lamp_count,
           shadow_spread, block_shadow, horiz_edge, overlap, left_col, right_col, last,
    input  ready
  );
  modport sink (
    input  valid, distance, bridge_shadow, corner_flag, ve_density, lamp_count,
           shadow_spread, block_shadow, horiz_edge, overlap, left_col, right_col, last,
    output ready
  );
endinterface

interface vcrc_out_if #(parameter int COLUMN_BITS = 10) ();
  logic                   valid;
  logic                   ready;
  logic [2:0]             vehicle_class;
  logic [COLUMN_BITS-1:0] left_bound;
  logic [COLUMN_BITS-1:0] right_bound;

  modport source (output valid, vehicle_class, left_bound, right_bound, input ready);
  modport sink (input valid, vehicle_class, left_bound, right_bound, output ready);
endinterface

`default_nettype wire

FILE: src/vehicle_candidate_rule_classifier.sv
// ============================================================================
// vehicle_candidate_rule_classifier
// Classifies the edge-pair groups of an image row and reports the row's
// best vehicle candidate.
// ----------------------------------------------------------------------------
// pairs carries one pair group per word; last marks the final group of a row.
// results carries one word per row: the first class in priority order
// (day, night lamp, night edge by lamp, night edge by horizontal edge, big
// black, corner) whose tracker holds a nonzero score, with that group's
// columns, or class none with zero columns. Rows are closed only by last.
// Throughput is one group per cycle unless a last word waits on results: the
// front classifies combinationally and pushes into a two-entry queue; the back
// updates the trackers of the word's class. With an empty queue the last group
// is held in a queue entry and its result word then in the output register.
// When results stalls, the back still takes non-last words; a last word waits
// until the output register frees, and the queue then fills and drops
// pairs.ready. Reset clears the queue, the trackers and the result valid flag.
// ============================================================================
`default_nettype none

module vehicle_candidate_rule_classifier #(
  parameter int COLUMN_BITS = 10
) (
  input  logic       clk,
  input  logic       rst,
  vcrc_in_if.sink    pairs,
  vcrc_out_if.source results
);
  import vcrc_pkg::*;

  localparam int DATA_BITS = $bits(vcrc_meas_t) + 2 * COLUMN_BITS;

  logic                   q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  logic [DATA_BITS-1:0]   q_push_data, q_pop_data;
  vcrc_meas_t             front_item, back_item;
  logic [COLUMN_BITS-1:0] front_left, front_right, back_left, back_right;

  vcrc_front #(.COLUMN_BITS(COLUMN_BITS)) u_front (
    .pairs      (pairs),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .item       (front_item),
    .item_left  (front_left),
    .item_right (front_right)
  );

  assign q_push_data = {front_item, front_left, front_right};

  vcrc_fifo #(.DATA_BITS(DATA_BITS)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  assign {back_item, back_left, back_right} = q_pop_data;

  vcrc_back #(.COLUMN_BITS(COLUMN_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_pop_valid),
    .item_ready (q_pop_ready),
    .item       (back_item),
    .item_left  (back_left),
    .item_right (back_right),
    .results    (results)
  );

  a_none_zero_bounds: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.vehicle_class == CLS_NONE |->
      results.left_bound == '0 && results.right_bound == '0)
    else $error("class none reported with nonzero columns");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(q_pop_valid && q_pop_ready && back_item.last))
    else $error("result raised without a last word leaving the queue");

  a_ready_follows_queue: assert property (@(posedge clk) disable iff (rst)
    pairs.ready == q_push_ready)
    else $error("input ready differs from queue space");

endmodule

`default_nettype wire

FILE: src/vcrc_front.sv
// ============================================================================
// vcrc_front
// Thresholds a pair group into levels, applies the ordered class rules and
// picks the ranking measures handed to the tracker stage.
// ============================================================================
`default_nettype none

module vcrc_front #(
  parameter int COLUMN_BITS = 10
) (
  vcrc_in_if.sink                pairs,
  output logic                   push_valid,
  input  logic                   push_ready,
  output vcrc_pkg::vcrc_meas_t   item,
  output logic [COLUMN_BITS-1:0] item_left,
  output logic [COLUMN_BITS-1:0] item_right
);
  import vcrc_pkg::*;

  logic        ve_hi, sd_hi, bb_hi, ov_ok, bsd_hi;
  logic [1:0]  lamp_lv, he_lv, ds_lv;
  vcrc_class_t cls;
  vcrc_score_t sd_mag, lamp_mag, he_mag, bb_mag, ve_mag;

  function automatic vcrc_score_t mag16(input logic signed [15:0] v);
    mag16 = v[15] ? vcrc_score_t'(-v) : vcrc_score_t'(v);
  endfunction

  assign ve_hi   = pairs.ve_density >= VE_HI_MIN;
  assign sd_hi   = pairs.shadow_spread >= SD_HI_MIN;
  assign bb_hi   = pairs.block_shadow >= BB_HI_MIN;
  assign ov_ok   = pairs.overlap >= OV_MIN;
  assign bsd_hi  = pairs.bridge_shadow > BSD_HI_ABOVE;
  assign lamp_lv = (pairs.lamp_count >= LAMP_LV2_MIN) ? 2'd2 :
                   (pairs.lamp_count >= LAMP_LV1_MIN) ? 2'd1 : 2'd0;
  assign he_lv   = (pairs.horiz_edge >= HE_LV2_MIN) ? 2'd2 :
                   (pairs.horiz_edge >= HE_LV1_MIN) ? 2'd1 : 2'd0;
  assign ds_lv   = (pairs.distance > DS_LV2_ABOVE) ? 2'd2 :
                   (pairs.distance > DS_LV1_ABOVE) ? 2'd1 : 2'd0;

  always_comb begin
    if (ve_hi && lamp_lv == 2'd0 && sd_hi && !bb_hi && he_lv != 2'd0 && !bsd_hi) begin
      cls = CLS_DAY;
    end else if ((lamp_lv != 2'd0 && ds_lv != 2'd0) ||
                 (lamp_lv == 2'd2 && ds_lv == 2'd0) ||
                 (he_lv != 2'd0 && lamp_lv != 2'd0 && ds_lv == 2'd0)) begin
      cls = CLS_NIGHT_LAMP;
    end else if (ve_hi && he_lv == 2'd2 && ds_lv != 2'd2 && !bsd_hi &&
                 !pairs.corner_flag) begin
      cls = CLS_NIGHT_EDGE;
    end else if (!sd_hi && bb_hi && ds_lv != 2'd2 && !bsd_hi) begin
      cls = CLS_BIG_BLACK;
    end else if (pairs.corner_flag && ds_lv != 2'd2 && !bsd_hi) begin
      cls = CLS_CORNER;
    end else begin
      cls = CLS_NONE;
    end
  end

  assign sd_mag   = mag16(pairs.shadow_spread);
  assign lamp_mag = mag16(pairs.lamp_count);
  assign he_mag   = mag16(pairs.horiz_edge);
  assign bb_mag   = mag16(pairs.block_shadow);
  assign ve_mag   = mag16(pairs.ve_density);

  always_comb begin
    item.cls    = cls;
    item.meas_b = he_mag;
    item.ov     = ov_ok ? vcrc_score_t'(pairs.overlap) : '0;
    item.last   = pairs.last;
    unique case (cls)
      CLS_DAY:                        item.meas_a = sd_mag;
      CLS_NIGHT_LAMP, CLS_NIGHT_EDGE: item.meas_a = lamp_mag;
      CLS_BIG_BLACK:                  item.meas_a = bb_mag;
      CLS_CORNER:                     item.meas_a = ve_mag;
      default:                        item.meas_a = '0;
    endcase
  end

  assign item_left   = pairs.left_col;
  assign item_right  = pairs.right_col;
  assign push_valid  = pairs.valid;
  assign pairs.ready = push_ready;

endmodule

`default_nettype wire

FILE: src/vcrc_fifo.sv
// ============================================================================
// vcrc_fifo
// Two-entry queue between the classifying front and the tracker back.
// ============================================================================
`default_nettype none

module vcrc_fifo #(
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  logic [DATA_BITS-1:0] push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output logic [DATA_BITS-1:0] pop_data
);
  import vcrc_pkg::*;

  logic [DATA_BITS-1:0] mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 push, pop;

  assign push_ready = count != QCNT_BITS'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/vcrc_back.sv
// ============================================================================
// vcrc_back
// Six best-score trackers, row-end priority pick and the result register.
// ============================================================================
`default_nettype none

module vcrc_back #(
  parameter int COLUMN_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  vcrc_pkg::vcrc_meas_t   item,
  input  logic [COLUMN_BITS-1:0] item_left,
  input  logic [COLUMN_BITS-1:0] item_right,
  vcrc_out_if.source             results
);
  import vcrc_pkg::*;

  vcrc_score_t            score       [NUM_TRACKERS];
  logic [COLUMN_BITS-1:0] trk_left    [NUM_TRACKERS];
  logic [COLUMN_BITS-1:0] trk_right   [NUM_TRACKERS];
  vcrc_score_t            score_next  [NUM_TRACKERS];
  logic [COLUMN_BITS-1:0] left_next   [NUM_TRACKERS];
  logic [COLUMN_BITS-1:0] right_next  [NUM_TRACKERS];
  vcrc_score_t            meas        [NUM_TRACKERS];
  vcrc_score_t            cmp         [NUM_TRACKERS];
  logic                   ov_win      [NUM_TRACKERS];
  logic                   meas_win    [NUM_TRACKERS];
  logic                   hit         [NUM_TRACKERS];

  logic                   take, found;
  vcrc_class_t            pick_cls;
  logic [COLUMN_BITS-1:0] pick_left, pick_right;

  logic                   res_valid;
  vcrc_class_t            res_cls;
  logic [COLUMN_BITS-1:0] res_left, res_right;

  assign item_ready = !item.last || !res_valid || results.ready;
  assign take       = item_valid && item_ready;

  always_comb begin
    for (int t = 0; t < NUM_TRACKERS; t++) begin
      meas[t]     = (t == MEAS_B_TRACKER) ? item.meas_b : item.meas_a;
      hit[t]      = take && TRK_CLASS[t] == item.cls;
      ov_win[t]   = item.ov > score[t];
      cmp[t]      = ov_win[t] ? item.ov : score[t];
      meas_win[t] = meas[t] > cmp[t];
      if (hit[t]) begin
        score_next[t] = meas_win[t] ? meas[t] : cmp[t];
      end else begin
        score_next[t] = score[t];
      end
      if (hit[t] && (ov_win[t] || meas_win[t])) begin
        left_next[t]  = item_left;
        right_next[t] = item_right;
      end else begin
        left_next[t]  = trk_left[t];
        right_next[t] = trk_right[t];
      end
    end
  end

  // first nonzero tracker after this word's update
  always_comb begin
    found      = 1'b0;
    pick_cls   = CLS_NONE;
    pick_left  = '0;
    pick_right = '0;
    for (int t = 0; t < NUM_TRACKERS; t++) begin
      if (!found && score_next[t] != '0) begin
        found      = 1'b1;
        pick_cls   = TRK_CLASS[t];
        pick_left  = left_next[t];
        pick_right = right_next[t];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && item.last)) begin
      for (int t = 0; t < NUM_TRACKERS; t++) begin
        score[t]     <= '0;
        trk_left[t]  <= '0;
        trk_right[t] <= '0;
      end
    end else begin
      for (int t = 0; t < NUM_TRACKERS; t++) begin
        score[t]     <= score_next[t];
        trk_left[t]  <= left_next[t];
        trk_right[t] <= right_next[t];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take && item.last) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.last) begin
      res_cls   <= pick_cls;
      res_left  <= pick_left;
      res_right <= pick_right;
    end
  end

  assign results.valid         = res_valid;
  assign results.vehicle_class = res_cls;
  assign results.left_bound    = res_left;
  assign results.right_bound   = res_right;

endmodule

`default_nettype wire
